FILE: hw/rtl/mrof_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrof_pkg
// Shared types and constants of the multi-region object free list.
// ----------------------------------------------------------------------------
package mrof_pkg;

	localparam int MaxRegions  = 4;
	localparam int StackDepth  = 256;
	localparam int HeaderBytes = 48;

	localparam int AddrW = 64;
	localparam int SizeW = 21;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_ADD   = 2'd2,
		OP_BAD   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NONE    = 3'd1,
		ST_INVALID = 3'd2,
		ST_SMALL   = 3'd3,
		ST_FULL    = 3'd4,
		ST_STACK   = 3'd5
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture request
		logic scan;      // evaluate region at scan position
		logic hdr_start; // start header remainder steps
		logic div_start;
		logic div_step;
		logic add_chk;   // register add checks
		logic commit;    // apply result to state
		logic stk_rd;    // stack read step; the stack RAM reads continuously
		logic fin;       // latch result
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] op;
		logic       scan_done;
		logic       hit;
		logic       div_done;
	} sts_t;

endpackage

FILE: hw/rtl/mrof_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrof_req_if / mrof_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface mrof_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [63:0] address;
	logic [63:0] region_end;
	logic [20:0] object_size;
	modport source (output valid, op, address, region_end, object_size, input ready);
	modport sink (input valid, op, address, region_end, object_size, output ready);
endinterface

interface mrof_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_address;
	logic [2:0]  status;
	modport source (output valid, result_address, status, input ready);
	modport sink (input valid, result_address, status, output ready);
endinterface

FILE: hw/rtl/mrof_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrof_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mrof_ram #(
	parameter int Width = 64,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: hw/rtl/mrof_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrof_ctrl
// Sequencer: region scan, add-region division and result handoff.
// ----------------------------------------------------------------------------
module mrof_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  mrof_pkg::sts_t sts,
	output mrof_pkg::cmd_t cmd
);
	typedef enum logic [8:0] {
		S_IDLE  = 9'b0_0000_0001,
		S_SCAN  = 9'b0_0000_0010,
		S_CHK   = 9'b0_0000_0100,
		S_DIV   = 9'b0_0000_1000,
		S_RD    = 9'b0_0001_0000,
		S_WAIT  = 9'b0_0010_0000,
		S_FIN   = 9'b0_0100_0000,
		S_OUT   = 9'b0_1000_0000,
		S_HDIV  = 9'b1_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.op == mrof_pkg::OP_ADD) begin
					cmd.hdr_start = 1'b1;
					state_d       = S_HDIV;
				end else if (sts.op == mrof_pkg::OP_BAD) begin
					state_d = S_FIN;
				end else if (sts.hit || sts.scan_done) begin
					state_d = S_RD;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_HDIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.add_chk = 1'b1;
					state_d     = S_CHK;
				end
			end
			S_CHK: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = S_FIN;
				end
			end
			S_RD: begin
				cmd.stk_rd = 1'b1;
				state_d    = S_WAIT;
			end
			S_WAIT: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin    = 1'b1;
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: hw/rtl/mrof_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrof_dp
// Region table, freed-address stacks, search order and slot-count divider.
// ----------------------------------------------------------------------------
module mrof_dp #(
	parameter int MaxRegions  = mrof_pkg::MaxRegions,
	parameter int StackDepth  = mrof_pkg::StackDepth,
	parameter int HeaderBytes = mrof_pkg::HeaderBytes
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     op,
	input  logic [63:0]    address,
	input  logic [63:0]    region_end,
	input  logic [20:0]    object_size,
	input  mrof_pkg::cmd_t cmd,
	output mrof_pkg::sts_t sts,
	output logic [63:0]    result_address,
	output logic [2:0]     status
);
	localparam int RW  = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
	localparam int CW  = $clog2(MaxRegions + 1);
	localparam int SW  = (StackDepth > 1) ? $clog2(StackDepth) : 1;
	localparam int DW  = $clog2(StackDepth + 1);
	localparam int MW  = RW + SW;
	localparam int HW  = $clog2(HeaderBytes + 1);
	localparam logic [63:0] Hdr    = 64'(HeaderBytes);
	localparam logic [63:0] HdrTop = Hdr << (64 - HW);

	logic [RW-1:0] order_q [MaxRegions];
	logic [CW-1:0] used_q;
	logic [63:0]   lo_q [MaxRegions];
	logic [63:0]   hi_q [MaxRegions];
	logic [63:0]   fresh_q [MaxRegions];
	logic [20:0]   sz_q [MaxRegions];
	logic [63:0]   nfree_q [MaxRegions];
	logic [DW-1:0] depth_q [MaxRegions];

	logic [1:0]    op_q;
	logic [63:0]   a_q, end_q;
	logic [20:0]   size_q;
	logic [CW-1:0] pos_q;
	logic          hit_q;
	logic [RW-1:0] reg_q;
	logic [2:0]    st_q;
	logic [63:0]   res_q;

	// add-region scratch
	logic [63:0] first_q, last_q, rem_q, quo_q;
	logic [6:0]  cnt_q;
	logic        div_busy_q;

	// scan evaluation
	logic [RW-1:0] r_cur;
	logic          in_rng, has_free, cur_hit;
	assign r_cur    = order_q[pos_q[RW-1:0]];
	assign in_rng   = (lo_q[r_cur] <= a_q) && (a_q <= hi_q[r_cur]);
	assign has_free = (nfree_q[r_cur] != 64'd0);
	assign cur_hit  = (op_q == mrof_pkg::OP_ALLOC) ? has_free : in_rng;

	assign sts.op        = op_q;
	assign sts.hit       = hit_q;
	assign sts.scan_done = (pos_q >= used_q) ||
		(op_q == mrof_pkg::OP_FREE && a_q == 64'd0);
	assign sts.div_done  = div_busy_q && (cnt_q == 7'd0);

	// freed-address stack memory
	logic          m_we;
	logic [MW-1:0] m_addr;
	logic [63:0]   m_rd;
	logic [SW-1:0] top_idx;
	assign top_idx = (op_q == mrof_pkg::OP_ALLOC) ?
		SW'(depth_q[reg_q] - DW'(1)) : SW'(depth_q[reg_q]);
	assign m_addr = {reg_q, top_idx};

	mrof_ram #(.Width(64), .Depth(2 ** MW)) u_stack (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(a_q), .rdata(m_rd)
	);

	// final decision
	logic [2:0]  st_d;
	logic [63:0] res_d;
	always_comb begin
		st_d  = mrof_pkg::ST_OK;
		res_d = 64'd0;
		m_we  = 1'b0;
		unique case (op_q)
			mrof_pkg::OP_ALLOC: begin
				if (!hit_q) begin
					st_d = mrof_pkg::ST_NONE;
				end else if (depth_q[reg_q] != '0) begin
					res_d = m_rd;
				end else begin
					res_d = fresh_q[reg_q];
				end
			end
			mrof_pkg::OP_FREE: begin
				if (a_q == 64'd0) begin
					st_d = mrof_pkg::ST_INVALID;
				end else if (!hit_q) begin
					st_d = mrof_pkg::ST_NONE;
				end else if (depth_q[reg_q] >= DW'(StackDepth)) begin
					st_d = mrof_pkg::ST_STACK;
				end else begin
					res_d = a_q;
					m_we  = cmd.commit;
				end
			end
			mrof_pkg::OP_ADD: begin
				st_d  = st_q;
				res_d = (st_q == mrof_pkg::ST_OK) ? first_q : 64'd0;
			end
			default: st_d = mrof_pkg::ST_INVALID;
		endcase
	end

	// header space is the next slot multiple above the header: header - rem + size
	logic [63:0] sz64, first_c, last_c;
	assign sz64    = 64'(size_q);
	assign first_c = a_q + Hdr - rem_q + sz64;
	assign last_c  = end_q - sz64;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			a_q    <= address;
			end_q  <= region_end;
			size_q <= object_size;
		end
		if (cmd.add_chk) begin
			first_q <= first_c;
			last_q  <= last_c;
			if (a_q > end_q || size_q == '0) begin
				st_q <= mrof_pkg::ST_INVALID;
			end else if (end_q - a_q < sz64 + Hdr || last_c <= first_c) begin
				st_q <= mrof_pkg::ST_SMALL;
			end else if (used_q >= CW'(MaxRegions)) begin
				st_q <= mrof_pkg::ST_FULL;
			end else begin
				st_q <= mrof_pkg::ST_OK;
			end
		end
		if (cmd.hdr_start) begin
			// header bits sit at the top so HW steps leave its remainder
			rem_q <= 64'd0;
			quo_q <= HdrTop;
		end else if (cmd.div_start) begin
			rem_q <= 64'd0;
			quo_q <= last_q - first_q - 64'd1;
		end else if (cmd.div_step && !sts.div_done) begin
			// restoring division, one quotient bit per cycle
			if ({rem_q[62:0], quo_q[63]} >= sz64) begin
				rem_q <= {rem_q[62:0], quo_q[63]} - sz64;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
		if (cmd.fin) begin
			st_q  <= st_d;
			res_q <= res_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxRegions; i++) begin
				order_q[i] <= RW'(i);
				depth_q[i] <= '0;
			end
			used_q     <= '0;
			pos_q      <= '0;
			hit_q      <= 1'b0;
			reg_q      <= '0;
			cnt_q      <= '0;
			div_busy_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				pos_q <= '0;
				hit_q <= 1'b0;
			end
			if (cmd.scan) begin
				if (cur_hit) begin
					hit_q <= 1'b1;
					reg_q <= r_cur;
				end else begin
					pos_q <= pos_q + CW'(1);
				end
			end
			if (cmd.hdr_start) begin
				cnt_q      <= 7'(HW);
				div_busy_q <= 1'b1;
			end else if (cmd.div_start) begin
				cnt_q      <= 7'd64;
				div_busy_q <= 1'b1;
			end else if (cmd.div_step && cnt_q != 7'd0) begin
				cnt_q <= cnt_q - 7'd1;
			end
			if (cmd.commit) begin
				div_busy_q <= 1'b0;
				if (op_q == mrof_pkg::OP_ALLOC && hit_q) begin
					if (pos_q[RW-1:0] != '0) begin
						order_q[0]             <= order_q[pos_q[RW-1:0]];
						order_q[pos_q[RW-1:0]] <= order_q[0];
					end
					if (depth_q[reg_q] != '0) begin
						depth_q[reg_q] <= depth_q[reg_q] - DW'(1);
					end
				end else if (st_d == mrof_pkg::ST_OK && op_q == mrof_pkg::OP_FREE) begin
					depth_q[reg_q] <= depth_q[reg_q] + DW'(1);
				end else if (op_q == mrof_pkg::OP_ADD && st_q == mrof_pkg::ST_OK) begin
					depth_q[used_q[RW-1:0]] <= '0;
					for (int k = 1; k < MaxRegions; k++) begin
						if (CW'(k) <= used_q) begin
							order_q[k] <= order_q[k-1];
						end
					end
					order_q[0] <= used_q[RW-1:0];
					used_q     <= used_q + CW'(1);
				end
			end
		end
	end

	// region payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (op_q == mrof_pkg::OP_ALLOC && hit_q) begin
				nfree_q[reg_q] <= nfree_q[reg_q] - 64'd1;
				if (depth_q[reg_q] == '0) begin
					fresh_q[reg_q] <= fresh_q[reg_q] + 64'(sz_q[reg_q]);
				end
			end else if (st_d == mrof_pkg::ST_OK && op_q == mrof_pkg::OP_FREE) begin
				nfree_q[reg_q] <= nfree_q[reg_q] + 64'd1;
			end else if (op_q == mrof_pkg::OP_ADD && st_q == mrof_pkg::ST_OK) begin
				lo_q[used_q[RW-1:0]]    <= first_q;
				hi_q[used_q[RW-1:0]]    <= last_q;
				fresh_q[used_q[RW-1:0]] <= first_q;
				sz_q[used_q[RW-1:0]]    <= size_q;
				nfree_q[used_q[RW-1:0]] <= quo_q + 64'd1;
			end
		end
	end

	assign result_address = res_q;
	assign status         = st_q;
endmodule

FILE: hw/rtl/multi_region_object_freelist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_region_object_freelist
// Fixed-size object allocator over several memory regions.
// ----------------------------------------------------------------------------
// allocate / free: region scan, stack read, read wait, then the result latch
// add region: header remainder steps, add checks and the 64-step slot count
//   divider, then the result latch; unknown op: straight from scan to the latch
// one request in flight; the next one is taken in the cycle after the result transfer
// reset empties the region table and restores the identity search order
module multi_region_object_freelist #(
	parameter int MaxRegions  = mrof_pkg::MaxRegions,
	parameter int StackDepth  = mrof_pkg::StackDepth,
	parameter int HeaderBytes = mrof_pkg::HeaderBytes
) (
	input logic       clk,
	input logic       arst_n,
	mrof_req_if.sink  req,
	mrof_rsp_if.source rsp
);
	mrof_pkg::cmd_t cmd;
	mrof_pkg::sts_t sts;

	mrof_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts(sts), .cmd(cmd)
	);

	mrof_dp #(
		.MaxRegions(MaxRegions), .StackDepth(StackDepth), .HeaderBytes(HeaderBytes)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.op(req.op), .address(req.address), .region_end(req.region_end),
		.object_size(req.object_size),
		.cmd(cmd), .sts(sts),
		.result_address(rsp.result_address), .status(rsp.status)
	);
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-region object free list. A bit-exact
// predictor tracks the region table, search order and freed stacks; every
// result transfer is compared in order against the predicted address and
// status; both channels idle and stall at random up to the last phase.
// ----------------------------------------------------------------------------
module tb;

	localparam int  MaxReg     = 4;
	localparam int  FreedDepth = 256;
	localparam int  HdrBytes   = 48;
	localparam int  CycleLimit = 600000;

	typedef struct packed {
		logic [63:0]       addr;
		mrof_pkg::status_t st;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mrof_req_if req_if();
	mrof_rsp_if rsp_if();

	multi_region_object_freelist dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predicted allocator state
	logic [1:0]  order_q [MaxReg];
	int          regions_used;
	logic [63:0] region_lo [MaxReg];
	logic [63:0] region_hi [MaxReg];
	logic [63:0] fresh_addr [MaxReg];
	logic [20:0] slot_size [MaxReg];
	logic [63:0] slots_left [MaxReg];
	int          freed_cnt [MaxReg];
	logic [63:0] freed_addr [MaxReg][FreedDepth];

	outcome_t    pending_q[$];
	logic [63:0] live_addrs[$];

	int cycle_cnt = 0;
	int hold_until = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int sent = 0;
	int status_seen [6];

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("tb: timeout after %0d cycles", cycle_cnt);
			$display("tb: errors");
			$finish;
		end
	end

	// receiver: long hold-off window, otherwise random stalls
	always @(posedge clk) begin
		if (cycle_cnt < hold_until)
			rsp_if.ready <= 1'b0;
		else
			rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("tb: unexpected result addr=%h status=%0d",
						rsp_if.result_address, rsp_if.status);
			end else begin
				want = pending_q.pop_front();
				if (rsp_if.result_address !== want.addr || rsp_if.status !== want.st) begin
					errors++;
					if (errors <= 10)
						$display("tb: mismatch exp addr=%h status=%0d got addr=%h status=%0d",
							want.addr, want.st, rsp_if.result_address, rsp_if.status);
				end
			end
		end
	end

	function automatic outcome_t predict_alloc();
		outcome_t o;
		int r;
		logic [1:0] t;
		o = '{addr: '0, st: mrof_pkg::ST_NONE};
		for (int p = 0; p < regions_used; p++) begin
			r = order_q[p];
			if (slots_left[r] != 0) begin
				t = order_q[0];
				order_q[0] = order_q[p];
				order_q[p] = t;
				if (freed_cnt[r] != 0) begin
					freed_cnt[r]--;
					o.addr = freed_addr[r][freed_cnt[r]];
				end else begin
					o.addr = fresh_addr[r];
					fresh_addr[r] = fresh_addr[r] + slot_size[r];
				end
				slots_left[r] = slots_left[r] - 1;
				o.st = mrof_pkg::ST_OK;
				return o;
			end
		end
		return o;
	endfunction

	function automatic outcome_t predict_free(logic [63:0] a);
		outcome_t o;
		int r;
		o = '{addr: '0, st: mrof_pkg::ST_NONE};
		if (a == 0) begin
			o.st = mrof_pkg::ST_INVALID;
			return o;
		end
		for (int p = 0; p < regions_used; p++) begin
			r = order_q[p];
			if (region_lo[r] <= a && a <= region_hi[r]) begin
				if (freed_cnt[r] >= FreedDepth) begin
					o.st = mrof_pkg::ST_STACK;
					return o;
				end
				freed_addr[r][freed_cnt[r]] = a;
				freed_cnt[r]++;
				slots_left[r] = slots_left[r] + 1;
				o = '{addr: a, st: mrof_pkg::ST_OK};
				return o;
			end
		end
		return o;
	endfunction

	function automatic outcome_t predict_add(logic [63:0] start, logic [63:0] stop,
			logic [20:0] sz);
		outcome_t o;
		logic [63:0] size64, hdr, first, last;
		int id;
		o = '{addr: '0, st: mrof_pkg::ST_OK};
		size64 = 64'(sz);
		if (start > stop || sz == 0) begin
			o.st = mrof_pkg::ST_INVALID;
			return o;
		end
		if (stop - start < size64 + HdrBytes) begin
			o.st = mrof_pkg::ST_SMALL;
			return o;
		end
		hdr = (64'(HdrBytes) / size64 + 1) * size64;
		first = start + hdr;
		last = stop - size64;
		if (last <= first) begin
			o.st = mrof_pkg::ST_SMALL;
			return o;
		end
		if (regions_used >= MaxReg) begin
			o.st = mrof_pkg::ST_FULL;
			return o;
		end
		id = regions_used;
		region_lo[id] = first;
		region_hi[id] = last;
		fresh_addr[id] = first;
		slot_size[id] = sz;
		slots_left[id] = (last - first - 1) / size64 + 1;
		freed_cnt[id] = 0;
		for (int k = id; k > 0; k--)
			order_q[k] = order_q[k - 1];
		order_q[0] = 2'(id);
		regions_used = id + 1;
		o.addr = first;
		return o;
	endfunction

	// drive one request and wait for its transfer; valid stays high afterwards
	task automatic send_req(mrof_pkg::op_t op, logic [63:0] a, logic [63:0] stop,
			logic [20:0] sz);
		outcome_t o;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op <= op;
		req_if.address <= a;
		req_if.region_end <= stop;
		req_if.object_size <= sz;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		case (op)
			mrof_pkg::OP_ALLOC: o = predict_alloc();
			mrof_pkg::OP_FREE:  o = predict_free(a);
			mrof_pkg::OP_ADD:   o = predict_add(a, stop, sz);
			default:            o = '{addr: '0, st: mrof_pkg::ST_INVALID};
		endcase
		if (op == mrof_pkg::OP_ALLOC && o.st == mrof_pkg::ST_OK)
			live_addrs.push_back(o.addr);
		status_seen[o.st]++;
		pending_q.push_back(o);
		sent++;
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic test_directed();
		send_req(mrof_pkg::OP_ALLOC, '0, '0, '0);
		send_req(mrof_pkg::OP_FREE, '0, '0, '0);
		send_req(mrof_pkg::OP_FREE, 64'h123, '0, '0);
		send_req(mrof_pkg::OP_BAD, '1, '1, 21'h1FFFFF);
		send_req(mrof_pkg::OP_ADD, 64'h2000, 64'h1000, 21'd16);
		send_req(mrof_pkg::OP_ADD, 64'h1000, 64'h2000, 21'd0);
		send_req(mrof_pkg::OP_ADD, 64'h1000, 64'h1040, 21'd32);
		// header swallows every slot
		send_req(mrof_pkg::OP_ADD, 64'h0, 64'h60, 21'd48);
		send_req(mrof_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_0000, '1, 21'd1048576);
		send_req(mrof_pkg::OP_ADD, 64'h1000, 64'h10D0, 21'd16);
		send_req(mrof_pkg::OP_ADD, 64'hFFFF_FFFF_FF00_0000, '1, 21'd1048576);
		repeat (10)
			send_req(mrof_pkg::OP_ALLOC, '0, '0, '0);
		send_req(mrof_pkg::OP_FREE, 64'h1041, '0, '0);
		send_req(mrof_pkg::OP_FREE, 64'h10C0, '0, '0);
		send_req(mrof_pkg::OP_FREE, 64'h10C1, '0, '0);
		send_req(mrof_pkg::OP_ALLOC, '0, '0, '0);
		send_req(mrof_pkg::OP_ALLOC, '0, '0, '0);
	endtask

	task automatic test_fill_table();
		logic [63:0] start;
		logic [20:0] sz;
		while (regions_used < MaxReg) begin
			start = rand64() & ~64'hFFFFF;
			sz = 21'($urandom_range(1, 64));
			send_req(mrof_pkg::OP_ADD, start,
				start + 64'(HdrBytes) + 64'(sz) * $urandom_range(12, 60), sz);
		end
		send_req(mrof_pkg::OP_ADD, 64'h5000, 64'h9000, 21'd8);
	endtask

	task automatic test_random(int n);
		int pick, idx, r;
		logic [63:0] a;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				send_req(mrof_pkg::OP_ALLOC, rand64(), rand64(), 21'($urandom));
			else if (pick < 80 && live_addrs.size() != 0) begin
				idx = $urandom_range(0, live_addrs.size() - 1);
				a = live_addrs[idx];
				live_addrs.delete(idx);
				send_req(mrof_pkg::OP_FREE, a, rand64(), 21'($urandom));
			end else if (pick < 86) begin
				r = $urandom_range(0, MaxReg - 1);
				a = region_lo[r] + $urandom_range(0, 64);
				send_req(mrof_pkg::OP_FREE, a, '0, '0);
			end else if (pick < 91)
				send_req(mrof_pkg::OP_FREE, rand64(), rand64(), 21'($urandom));
			else if (pick < 96) begin
				a = rand64();
				send_req(mrof_pkg::OP_ADD, a,
					($urandom_range(0, 1)) ? rand64() : a + $urandom_range(0, 4096),
					21'($urandom_range(0, 1048576)));
			end else if (pick < 98)
				send_req(mrof_pkg::OP_BAD, rand64(), rand64(), 21'($urandom));
			else
				send_req(mrof_pkg::OP_FREE, '0, rand64(), 21'($urandom));
		end
	endtask

	// the same address pushed until its region's freed stack overflows
	task automatic test_stack_full();
		repeat (FreedDepth + 4)
			send_req(mrof_pkg::OP_FREE, 64'h1050, '0, '0);
		repeat (6)
			send_req(mrof_pkg::OP_ALLOC, '0, '0, '0);
	endtask

	task automatic test_backpressure();
		hold_until = cycle_cnt + 300;
		test_random(20);
		wait_drained();
		test_random(10);
		wait_drained();
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.op = mrof_pkg::OP_ALLOC;
		req_if.address = '0;
		req_if.region_end = '0;
		req_if.object_size = '0;
		for (int i = 0; i < MaxReg; i++) begin
			order_q[i] = 2'(i);
			freed_cnt[i] = 0;
			region_lo[i] = '0;
			region_hi[i] = '0;
			fresh_addr[i] = '0;
			slot_size[i] = '0;
			slots_left[i] = '0;
		end
		for (int i = 0; i < 6; i++)
			status_seen[i] = 0;
		regions_used = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 18;
		recv_stall_pct = 67;
		test_directed();
		test_fill_table();
		test_random(140);
		test_backpressure();
		send_idle_pct = 67;
		recv_stall_pct = 18;
		test_stack_full();
		test_random(140);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(140);

		wait_drained();
		repeat (100) @(posedge clk);
		$display("tb: %0d requests; ok %0d, none %0d, invalid %0d, small %0d, full %0d, stack %0d",
			sent, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4], status_seen[5]);
		$display("tb: %0d mismatches over region adds, allocs, frees and stalls", errors);
		if (errors == 0 && pending_q.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/mrof_pkg.sv
hw/rtl/mrof_if.sv
hw/rtl/mrof_ram.sv
hw/rtl/mrof_ctrl.sv
hw/rtl/mrof_dp.sv
hw/rtl/multi_region_object_freelist.sv
tb/tb.sv
